@@ hw/rtl/diagonal_smoothstep_alpha_mask_assert.svh @@
// Assertion macros used by the checker in dsam_checker.sv.
`ifndef DIAGONAL_SMOOTHSTEP_ALPHA_MASK_ASSERT_SVH
`define DIAGONAL_SMOOTHSTEP_ALPHA_MASK_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define DSAM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dsam assertion failed");

// Next-cycle implication.
`define DSAM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dsam assertion failed");

`endif

@@ hw/rtl/dsam_pkg.sv @@
package dsam_pkg;

    localparam int COORD_BITS = 11;
    localparam int SIDE_W     = 12;
    localparam int WIDTH_W    = 13;
    localparam int DIV_W      = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SQUARE_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH = 2'd1;

    localparam logic [SIDE_W-1:0]  SQUARE_SIZE_RST  = 12'd480;
    localparam logic [WIDTH_W-1:0] SCREEN_WIDTH_RST = 13'd640;

    typedef struct packed {
        logic [COORD_BITS-1:0] col;
        logic [COORD_BITS-1:0] row;
        logic [31:0]           pixel;
    } in_t;

    typedef struct packed {
        logic signed [12:0]    screen_x;
        logic [COORD_BITS-1:0] screen_y;
        logic [31:0]           out_pixel;
        logic                  write_enable;
    } out_t;

    // Data that rides along the divider chain.
    typedef struct packed {
        logic                  valid;
        logic                  sat;
        logic                  on_screen;
        logic [12:0]           screen_x;
        logic [COORD_BITS-1:0] screen_y;
        logic [23:0]           rgb;
    } side_t;

endpackage

@@ hw/rtl/dsam_front.sv @@
module dsam_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  dsam_pkg::in_t                     req,
    input  logic [dsam_pkg::SIDE_W-1:0]       square_size,
    input  logic [dsam_pkg::WIDTH_W-1:0]      screen_width,
    output dsam_pkg::side_t                   side,
    output logic [dsam_pkg::DIV_W-1:0]        rem,
    output logic [dsam_pkg::DIV_W-1:0]        total
);

    logic signed [18:0] side_s, x_s, y_s, w_s;
    logic signed [18:0] d10, total10, adj10, sx;
    logic               live, sat, on_scr;

    dsam_pkg::side_t             side_reg, side_next;
    logic [dsam_pkg::DIV_W-1:0]  rem_reg, rem_next;
    logic [dsam_pkg::DIV_W-1:0]  total_reg, total_next;

    always_comb
    begin
        side_s  = signed'({7'b0, square_size});
        x_s     = signed'({8'b0, req.col});
        y_s     = signed'({8'b0, req.row});
        w_s     = signed'({6'b0, screen_width});
        d10     = (y_s < side_s) ? 19'sd5 * (side_s - y_s) : 19'sd0;
        total10 = 19'sd12 * side_s - d10;
        adj10   = 19'sd10 * x_s - d10 + 19'sd2 * side_s;
        live    = (adj10 > 19'sd0) && (total10 > 19'sd0);
        sat     = live && (adj10 >= total10);
        sx      = w_s - side_s + x_s;
        on_scr  = (sx >= 19'sd0) && (sx < w_s) && (y_s < side_s);

        side_next.valid     = accept;
        side_next.sat       = sat;
        side_next.on_screen = on_scr;
        side_next.screen_x  = sx[12:0];
        side_next.screen_y  = req.row;
        side_next.rgb       = req.pixel[31:8];
        rem_next   = (live && !sat) ? adj10[dsam_pkg::DIV_W-1:0] : '0;
        total_next = total10[dsam_pkg::DIV_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg  <= '0;
            rem_reg   <= '0;
            total_reg <= '0;
        end
        else
        begin
            side_reg  <= side_next;
            rem_reg   <= rem_next;
            total_reg <= total_next;
        end
    end

    assign side  = side_reg;
    assign rem   = rem_reg;
    assign total = total_reg;

endmodule

@@ hw/rtl/dsam_div_cell.sv @@
// One restoring-division step: one quotient bit per cell.
module dsam_div_cell #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dsam_pkg::side_t               side_in,
    input  logic [dsam_pkg::DIV_W-1:0]    rem_in,
    input  logic [dsam_pkg::DIV_W-1:0]    total_in,
    input  logic [FRAC_BITS-1:0]          q_in,
    output dsam_pkg::side_t               side_out,
    output logic [dsam_pkg::DIV_W-1:0]    rem_out,
    output logic [dsam_pkg::DIV_W-1:0]    total_out,
    output logic [FRAC_BITS-1:0]          q_out
);

    logic [dsam_pkg::DIV_W:0]     r2, diff;
    logic                         bit_q;
    dsam_pkg::side_t              side_reg;
    logic [dsam_pkg::DIV_W-1:0]   rem_reg, rem_next, total_reg;
    logic [FRAC_BITS-1:0]         q_reg, q_next;

    always_comb
    begin
        r2       = {rem_in, 1'b0};
        diff     = r2 - {1'b0, total_in};
        bit_q    = (r2 >= {1'b0, total_in});
        rem_next = bit_q ? diff[dsam_pkg::DIV_W-1:0] : r2[dsam_pkg::DIV_W-1:0];
        q_next   = {q_in[FRAC_BITS-2:0], bit_q};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg  <= '0;
            rem_reg   <= '0;
            total_reg <= '0;
            q_reg     <= '0;
        end
        else
        begin
            side_reg  <= side_in;
            rem_reg   <= rem_next;
            total_reg <= total_in;
            q_reg     <= q_next;
        end
    end

    assign side_out  = side_reg;
    assign rem_out   = rem_reg;
    assign total_out = total_reg;
    assign q_out     = q_reg;

endmodule

@@ hw/rtl/dsam_back.sv @@
// Smoothstep, alpha and write flag, three register stages.
module dsam_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dsam_pkg::side_t       side_in,
    input  logic [FRAC_BITS-1:0]  q_in,
    output logic                  result_valid,
    output dsam_pkg::out_t        result
);

    localparam int FW = FRAC_BITS + 1;
    localparam logic [FW-1:0]        ONE   = FW'(1) << FRAC_BITS;
    localparam logic [FRAC_BITS+1:0] THREE = (FRAC_BITS + 2)'(3) << FRAC_BITS;

    logic [FW-1:0]            f;
    logic [2*FW-1:0]          ff;
    logic [FRAC_BITS+1:0]     t;
    logic [2*FW+1:0]          st;
    logic [FRAC_BITS+8:0]     a_prod;
    logic [FRAC_BITS+10:0]    v_prod;
    logic                     we;

    dsam_pkg::side_t      s1_reg, s2_reg;
    logic [FW-1:0]        f_reg, f2_reg, s_reg;
    logic                 valid_reg;
    dsam_pkg::out_t       out_reg, out_next;

    always_comb
    begin
        f      = side_in.sat ? ONE : {1'b0, q_in};
        ff     = f * f;
        t      = THREE - {f_reg, 1'b0};
        st     = f2_reg * t;
        a_prod = s_reg * 9'd204;
        v_prod = s_reg * 11'd800;
        we     = (v_prod > {{10{1'b0}}, ONE}) && s2_reg.on_screen;

        out_next.screen_x     = s2_reg.screen_x;
        out_next.screen_y     = s2_reg.screen_y;
        out_next.out_pixel    = we ? {s2_reg.rgb, a_prod[FRAC_BITS+7:FRAC_BITS]} : 32'd0;
        out_next.write_enable = we;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg    <= '0;
            s2_reg    <= '0;
            valid_reg <= 1'b0;
            f_reg     <= '0;
            f2_reg    <= '0;
            s_reg     <= '0;
            out_reg   <= '0;
        end
        else
        begin
            s1_reg    <= side_in;
            f_reg     <= f;
            f2_reg    <= ff[2*FRAC_BITS:FRAC_BITS];

            s2_reg    <= s1_reg;
            s_reg     <= st[2*FRAC_BITS:FRAC_BITS];

            valid_reg <= s2_reg.valid;
            out_reg   <= out_next;
        end
    end

    assign result_valid = valid_reg;
    assign result       = out_reg;

endmodule

@@ hw/rtl/diagonal_smoothstep_alpha_mask.sv @@
// Channel   | Signals                                   | Handshake
// ----------+-------------------------------------------+---------------------------
// request   | start, busy, req                          | start && !busy
// result    | result_valid, result                      | strobe, one cycle, no stall
// config    | cfg_valid, cfg_ready, cfg_index, cfg_data | cfg_valid && cfg_ready
//
// One request per clock; busy is always low.
// Pipeline: front stage, one divider cell per
// quotient bit, then three smoothstep/alpha stages.
// rst_n clears valids and loads square_size 480, screen_width 640.
// The result side cannot stall, so the chain never holds.
module diagonal_smoothstep_alpha_mask #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  dsam_pkg::in_t                     req,
    output logic                              result_valid,
    output dsam_pkg::out_t                    result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dsam_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dsam_pkg::WIDTH_W-1:0]      cfg_data
);

    logic [dsam_pkg::SIDE_W-1:0]   square_size_reg, square_size_next;
    logic [dsam_pkg::WIDTH_W-1:0]  screen_width_reg, screen_width_next;

    dsam_pkg::side_t               side_c  [0:FRAC_BITS];
    logic [dsam_pkg::DIV_W-1:0]    rem_c   [0:FRAC_BITS];
    logic [dsam_pkg::DIV_W-1:0]    total_c [0:FRAC_BITS];
    logic [FRAC_BITS-1:0]          q_c     [0:FRAC_BITS];

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        square_size_next  = square_size_reg;
        screen_width_next = screen_width_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                dsam_pkg::CFG_SQUARE_SIZE:
                    square_size_next = cfg_data[dsam_pkg::SIDE_W-1:0];
                dsam_pkg::CFG_SCREEN_WIDTH:
                    screen_width_next = cfg_data;
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            square_size_reg  <= dsam_pkg::SQUARE_SIZE_RST;
            screen_width_reg <= dsam_pkg::SCREEN_WIDTH_RST;
        end
        else
        begin
            square_size_reg  <= square_size_next;
            screen_width_reg <= screen_width_next;
        end
    end

    dsam_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (start && !busy),
        .req          (req),
        .square_size  (square_size_reg),
        .screen_width (screen_width_reg),
        .side         (side_c[0]),
        .rem          (rem_c[0]),
        .total        (total_c[0])
    );

    assign q_c[0] = '0;

    for (genvar i = 0; i < FRAC_BITS; i++)
    begin : g_div
        dsam_div_cell #(.FRAC_BITS(FRAC_BITS)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .side_in   (side_c[i]),
            .rem_in    (rem_c[i]),
            .total_in  (total_c[i]),
            .q_in      (q_c[i]),
            .side_out  (side_c[i+1]),
            .rem_out   (rem_c[i+1]),
            .total_out (total_c[i+1]),
            .q_out     (q_c[i+1])
        );
    end

    dsam_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .side_in      (side_c[FRAC_BITS]),
        .q_in         (q_c[FRAC_BITS]),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

@@ hw/rtl/dsam_checker.sv @@
`include "diagonal_smoothstep_alpha_mask_assert.svh"

module dsam_checker #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  dsam_pkg::in_t                     req,
    input  logic                              result_valid,
    input  dsam_pkg::out_t                    result
);

    localparam int LAT = FRAC_BITS + 4;

    logic acc, no_we, we_on;

    assign acc   = start && !busy;
    assign no_we = result_valid && !result.write_enable;
    assign we_on = result_valid && result.write_enable;

    `DSAM_ASSERT_NOW(a_latency, $past(acc, LAT), result_valid)
    `DSAM_ASSERT_NOW(a_row_kept, $past(acc, LAT), result.screen_y == $past(req.row, LAT))
    `DSAM_ASSERT_NOW(a_no_write_zero, no_we, result.out_pixel == 32'd0)
    `DSAM_ASSERT_NOW(a_alpha_cap, we_on, result.out_pixel[7:0] <= 8'd204)

endmodule

bind diagonal_smoothstep_alpha_mask dsam_checker #(.FRAC_BITS(FRAC_BITS)) u_dsam_checker (.*);

@@ tb/diagonal_smoothstep_alpha_mask_tb.sv @@
`timescale 1ns / 100ps

module diagonal_smoothstep_alpha_mask_tb;

    localparam int FRAC     = 16;
    localparam int LATENCY  = FRAC + 4;
    localparam int N_RANDOM = 1530;

    class alpha_mask_scoreboard;
        dsam_pkg::out_t pending[$];
        int unsigned    errors;
        logic [11:0]    side;
        logic [12:0]    width;

        function new();
            errors = 0;
            side   = dsam_pkg::SQUARE_SIZE_RST;
            width  = dsam_pkg::SCREEN_WIDTH_RST;
        endfunction

        function void note_request(dsam_pkg::in_t r);
            longint d10;
            longint total10;
            longint adj10;
            longint sx;
            longint x;
            longint y;
            longint sd;
            longint w;
            longint unsigned f;
            longint unsigned f2;
            longint unsigned s;
            longint unsigned a;
            longint unsigned one;
            bit we;
            dsam_pkg::out_t o;
            one = 64'd1 << FRAC;
            x = r.col;
            y = r.row;
            sd = side;
            w = width;
            d10 = (y < sd) ? 5 * (sd - y) : 0;
            total10 = 12 * sd - d10;
            adj10 = 10 * x - d10 + 2 * sd;
            s = 0;
            if (adj10 > 0 && total10 > 0)
            begin
                f = (longint'(adj10) << FRAC) / total10;
                if (f > one)
                    f = one;
                f2 = (f * f) >> FRAC;
                s = (f2 * (3 * one - 2 * f)) >> FRAC;
            end
            sx = w - sd + x;
            we = (s * 800 > one) && sx >= 0 && sx < w && y < sd;
            a = (s * 204) >> FRAC;
            if (a > 255)
                a = 255;
            o.screen_x = sx[12:0];
            o.screen_y = r.row;
            o.out_pixel = we ? {r.pixel[31:8], a[7:0]} : 32'd0;
            o.write_enable = we;
            pending.push_back(o);
        endfunction

        task report_mismatch(string what, logic [63:0] want, logic [63:0] got);
            $display("mismatch %s: want %h got %h at %0t", what, want, got, $time);
            errors++;
        endtask

        task check_result(dsam_pkg::out_t got);
            dsam_pkg::out_t want;
            if (pending.size() == 0)
            begin
                report_mismatch("unexpected result", 0, 64'(got));
                return;
            end
            want = pending.pop_front();
            if (got.screen_x !== want.screen_x)
                report_mismatch("screen_x", 64'(want.screen_x), 64'(got.screen_x));
            if (got.screen_y !== want.screen_y)
                report_mismatch("screen_y", 64'(want.screen_y), 64'(got.screen_y));
            if (got.out_pixel !== want.out_pixel)
                report_mismatch("out_pixel", 64'(want.out_pixel), 64'(got.out_pixel));
            if (got.write_enable !== want.write_enable)
                report_mismatch("write_enable", 64'(want.write_enable),
                                64'(got.write_enable));
        endtask
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           start;
    logic                           busy;
    dsam_pkg::in_t                  req;
    logic                           result_valid;
    dsam_pkg::out_t                 result;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [dsam_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [dsam_pkg::WIDTH_W-1:0]   cfg_data;

    alpha_mask_scoreboard sb;
    bit                   quiet;

    diagonal_smoothstep_alpha_mask #(.FRAC_BITS(FRAC)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            sb.check_result(result);
    end

    task automatic write_reg(logic [dsam_pkg::CFG_IDX_W-1:0] idx,
                             logic [dsam_pkg::WIDTH_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == dsam_pkg::CFG_SQUARE_SIZE)
            sb.side = val[11:0];
        else if (idx == dsam_pkg::CFG_SCREEN_WIDTH)
            sb.width = val;
    endtask

    task automatic send_pixel(logic [10:0] c, logic [10:0] r, logic [31:0] p);
        int gap;
        dsam_pkg::in_t item;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            gap = int'($urandom_range(1, 7));
            repeat (gap) @(posedge clk);
        end
        item.col = c;
        item.row = r;
        item.pixel = p;
        start <= 1'b1;
        req   <= item;
        do
            @(posedge clk);
        while (busy);
        sb.note_request(item);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic set_geometry(logic [11:0] s, logic [12:0] w);
        drain();
        write_reg(dsam_pkg::CFG_SQUARE_SIZE, {1'b0, s});
        write_reg(dsam_pkg::CFG_SCREEN_WIDTH, w);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_pixel();
        logic [10:0] c;
        logic [10:0] r;
        int lim;
        lim = (sb.side > 1) ? int'(sb.side) - 1 : 0;
        if (lim > 2047)
            lim = 2047;
        if ($urandom_range(0, 9) < 8)
        begin
            c = 11'($urandom_range(0, lim));
            r = 11'($urandom_range(0, lim));
        end
        else
        begin
            c = 11'($urandom);
            r = 11'($urandom);
        end
        send_pixel(c, r, $urandom);
    endtask

    initial
    begin
        logic [11:0] sides[6];
        logic [12:0] widths[6];
        sb = new();
        quiet = 0;
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_pixel(11'd0, 11'd0, 32'hFFFFFFFF);
        send_pixel(11'd479, 11'd0, 32'h12345678);
        send_pixel(11'd479, 11'd479, 32'hFFFFFFFF);
        send_pixel(11'd240, 11'd240, 32'hA5A5A5A5);
        send_pixel(11'd2047, 11'd2047, 32'h00000000);
        send_pixel(11'd0, 11'd479, 32'h5A5A5A5A);
        send_pixel(11'd600, 11'd100, 32'hDEADBEEF);
        send_pixel(11'd100, 11'd500, 32'hCAFEF00D);
        set_geometry(12'd0, 13'd640);
        send_pixel(11'd5, 11'd0, 32'hFFFFFF00);
        set_geometry(12'd2048, 13'd1);
        send_pixel(11'd2047, 11'd0, 32'hFFFFFFFF);
        send_pixel(11'd2047, 11'd2047, 32'h0F0F0F0F);
        send_pixel(11'd0, 11'd1024, 32'hFFFFFFFF);
        set_geometry(12'd1, 13'd4096);
        send_pixel(11'd0, 11'd0, 32'h87654321);
        send_pixel(11'd1, 11'd0, 32'hFFFFFFFF);
        set_geometry(12'd2048, 13'd4096);
        send_pixel(11'd2047, 11'd0, 32'hFFFFFFFF);
        send_pixel(11'd1000, 11'd1000, 32'h13579BDF);

        sides  = '{12'd480, 12'd7, 12'd2048, 12'd1, 12'd100, 12'd1200};
        widths = '{13'd640, 13'd4096, 13'd1, 13'd3, 13'd8191, 13'd1500};
        foreach (sides[i])
        begin
            set_geometry(sides[i], widths[i]);
            for (int n = 0; n < N_RANDOM / 6; n++)
            begin
                if (i == 5 && n > N_RANDOM / 12)
                    quiet = 1;
                random_pixel();
            end
        end
        drain();

        if (sb.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("FAILED: results differ");
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/dsam_pkg.sv
hw/rtl/dsam_front.sv
hw/rtl/dsam_div_cell.sv
hw/rtl/dsam_back.sv
hw/rtl/diagonal_smoothstep_alpha_mask.sv
hw/rtl/dsam_checker.sv
tb/diagonal_smoothstep_alpha_mask_tb.sv
